@@ rtl/pws_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pws_pkg
// shared types and constants of the perspective world to screen unit
// ----------------------------------------------------------------------------
package pws_pkg;

  localparam int CoordW = 32;
  localparam int DimW   = 15;
  localparam int IdxW   = 4;

  typedef enum logic [0:0] {
    MODE_COEF = 1'b0,
    MODE_PROJ = 1'b1
  } mode_t;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                     behind;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } screen_t;

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat32 = hi[CoordW-1:0];
    end else if (v < lo) begin
      sat32 = lo[CoordW-1:0];
    end else begin
      sat32 = v[CoordW-1:0];
    end
  endfunction

endpackage

@@ rtl/pws_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pws_divider
// pipelined restoring divider, one quotient bit per stage
// unsigned dividend / positive divisor, carries a tag along
// ----------------------------------------------------------------------------
module pws_divider #(
  parameter int NumW = 64,
  parameter int DenW = 34,
  parameter int TagW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  input  logic [TagW-1:0] tag_in,
  output logic            out_valid,
  output logic [NumW-1:0] quo,
  output logic [DenW-1:0] rem,
  output logic [TagW-1:0] tag_out
);

  logic            v   [0:NumW];
  logic [NumW-1:0] q   [0:NumW];
  logic [DenW-1:0] r   [0:NumW];
  logic [DenW-1:0] d   [0:NumW];
  logic [TagW-1:0] t   [0:NumW];

  assign v[0] = in_valid;
  assign q[0] = num;
  assign r[0] = '0;
  assign d[0] = den;
  assign t[0] = tag_in;

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [DenW:0]   trial;
    logic [NumW-1:0] q_sh;
    always_comb begin
      trial = {r[s], q[s][NumW-1]} - {1'b0, d[s]};
      q_sh  = {q[s][NumW-2:0], ~trial[DenW]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
      if (en) begin
        q[s+1] <= q_sh;
        r[s+1] <= trial[DenW] ? {r[s][DenW-2:0], q[s][NumW-1]} : trial[DenW-1:0];
        d[s+1] <= d[s];
        t[s+1] <= t[s];
      end
    end
  end

  assign out_valid = v[NumW];
  assign quo       = q[NumW];
  assign rem       = r[NumW];
  assign tag_out   = t[NumW];

endmodule

@@ rtl/pws_clip.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pws_clip
// coefficient store and three-row clip transform, three register stages
// ----------------------------------------------------------------------------
module pws_clip #(
  parameter int FracBits = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic                              mode,
  input  logic [pws_pkg::IdxW-1:0]          coef_index,
  input  logic signed [pws_pkg::CoordW-1:0] coef_value,
  input  logic signed [pws_pkg::CoordW-1:0] world_x,
  input  logic signed [pws_pkg::CoordW-1:0] world_y,
  input  logic signed [pws_pkg::CoordW-1:0] world_z,
  output logic                              out_valid,
  output logic signed [pws_pkg::CoordW-1:0] cx,
  output logic signed [pws_pkg::CoordW-1:0] cy,
  output logic signed [pws_pkg::CoordW-1:0] cw
);
  import pws_pkg::*;

  logic signed [CoordW-1:0] coef [0:15];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) coef[IdxW'(i)] <= '0;
    end else if (en && in_valid && mode == MODE_COEF) begin
      coef[coef_index] <= coef_value;
    end
  end

  // stage 1: nine products
  logic               v1;
  logic signed [63:0] p [0:2][0:2];
  logic signed [CoordW-1:0] off [0:2];
  localparam int RowSel [0:2] = '{0, 1, 3};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid && mode == MODE_PROJ;
    end
    if (en) begin
      for (int rr = 0; rr < 3; rr++) begin
        p[rr][0] <= 64'(world_x) * 64'(coef[IdxW'(RowSel[rr]*4+0)]);
        p[rr][1] <= 64'(world_y) * 64'(coef[IdxW'(RowSel[rr]*4+1)]);
        p[rr][2] <= 64'(world_z) * 64'(coef[IdxW'(RowSel[rr]*4+2)]);
        off[rr]  <= coef[IdxW'(RowSel[rr]*4+3)];
      end
    end
  end

  // stage 2: shifted sums
  logic               v2;
  logic signed [63:0] sum [0:2];
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      for (int rr = 0; rr < 3; rr++) begin
        sum[rr] <= (p[rr][0] >>> FracBits) + (p[rr][1] >>> FracBits)
                 + (p[rr][2] >>> FracBits) + 64'(off[rr]);
      end
    end
  end

  // stage 3: saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
    if (en) begin
      cx <= sat32(sum[0]);
      cy <= sat32(sum[1]);
      cw <= sat32(sum[2]);
    end
  end

endmodule

@@ rtl/pws_viewport.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pws_viewport
// viewport scale, two pipelined dividers and result saturation
// ----------------------------------------------------------------------------
module pws_viewport #(
  parameter int FracBits = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [pws_pkg::CoordW-1:0] cx,
  input  logic signed [pws_pkg::CoordW-1:0] cy,
  input  logic signed [pws_pkg::CoordW-1:0] cw,
  input  logic [pws_pkg::DimW-1:0]          screen_width,
  input  logic [pws_pkg::DimW-1:0]          screen_height,
  output logic                              out_valid,
  output pws_pkg::screen_t                  result
);
  import pws_pkg::*;

  localparam int DenW = 34;
  localparam int NumW = 50;
  localparam int TagW = 3;
  localparam logic signed [CoordW-1:0] NegOne = -(CoordW'(1) <<< FracBits);
  localparam logic signed [63:0] Lim = 64'sd1 <<< (31 - FracBits);

  // stage a: numerators (34 bit signed)
  logic                     va;
  logic signed [33:0]       nx, ny;
  logic signed [CoordW-1:0] wa;
  logic                     behind_a;
  logic [DimW-1:0]          sw_a, sh_a;
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
    if (en) begin
      nx       <= 34'(cx) + 34'(cw);
      ny       <= 34'(cw) - 34'(cy);
      wa       <= cw;
      behind_a <= cw <= 0;
      sw_a     <= screen_width;
      sh_a     <= screen_height;
    end
  end

  // stage b: scale, then magnitude
  logic               vb;
  logic signed [49:0] mx, my;
  logic [DenW-1:0]    den_b;
  logic               behind_b;
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
    if (en) begin
      mx       <= 50'(nx) * $signed({1'b0, sw_a});
      my       <= 50'(ny) * $signed({1'b0, sh_a});
      den_b    <= behind_a ? DenW'(1) : {1'b0, wa, 1'b0};
      behind_b <= behind_a;
    end
  end

  logic            vc;
  logic [NumW-1:0] ax, ay;
  logic [DenW-1:0] den_c;
  logic [TagW-1:0] tag_c;
  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
    if (en) begin
      ax    <= mx[49] ? NumW'(-mx) : NumW'(mx);
      ay    <= my[49] ? NumW'(-my) : NumW'(my);
      den_c <= den_b;
      tag_c <= {behind_b, mx[49], my[49]};
    end
  end

  logic            dvx, dvy;
  logic [NumW-1:0] qx, qy;
  logic [DenW-1:0] rx, ry, dx_o, dy_o;
  logic [TagW-1:0] tx, ty;

  pws_divider #(.NumW(NumW), .DenW(DenW), .TagW(TagW)) u_div_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(vc), .num(ax), .den(den_c),
    .tag_in(tag_c), .out_valid(dvx), .quo(qx), .rem(rx), .tag_out(tx)
  );
  pws_divider #(.NumW(NumW), .DenW(DenW), .TagW(TagW)) u_div_y (
    .clk(clk), .rst(rst), .en(en), .in_valid(vc), .num(ay), .den(den_c),
    .tag_in(tag_c), .out_valid(dvy), .quo(qy), .rem(ry), .tag_out(ty)
  );

  // divisor copy for floor correction and fraction stage
  logic [DenW-1:0] dpipe [0:NumW];
  assign dpipe[0] = den_c;
  for (genvar s = 0; s < NumW; s++) begin : g_dp
    always_ff @(posedge clk) begin
      if (en) dpipe[s+1] <= dpipe[s];
    end
  end
  assign dx_o = dpipe[NumW];
  assign dy_o = dpipe[NumW];

  // stage d: floor quotient and remainder
  logic               vd;
  logic signed [63:0] fqx, fqy;
  logic [DenW-1:0]    frx, fry, dd;
  logic               behind_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= dvx;
    end
    if (en) begin
      behind_d <= tx[2];
      dd       <= dx_o;
      if (tx[1] && rx != '0) begin
        fqx <= -64'($signed({1'b0, qx})) - 64'sd1;
        frx <= dx_o - rx;
      end else begin
        fqx <= tx[1] ? -64'($signed({1'b0, qx})) : 64'($signed({1'b0, qx}));
        frx <= rx;
      end
      if (ty[0] && ry != '0) begin
        fqy <= -64'($signed({1'b0, qy})) - 64'sd1;
        fry <= dy_o - ry;
      end else begin
        fqy <= ty[0] ? -64'($signed({1'b0, qy})) : 64'($signed({1'b0, qy}));
        fry <= ry;
      end
    end
  end

  // fraction: floor(r * 2^F / den), r < den, one bit per stage
  logic            fv  [0:FracBits];
  logic [DenW-1:0] fr  [0:1][0:FracBits];
  logic [FracBits-1:0] fb [0:1][0:FracBits];
  logic signed [63:0]  fq [0:1][0:FracBits];
  logic [DenW-1:0]     fd [0:FracBits];
  logic                fbh [0:FracBits];
  assign fv[0]    = vd;
  assign fr[0][0] = frx;
  assign fr[1][0] = fry;
  assign fb[0][0] = '0;
  assign fb[1][0] = '0;
  assign fq[0][0] = fqx;
  assign fq[1][0] = fqy;
  assign fd[0]    = dd;
  assign fbh[0]   = behind_d;
  for (genvar s = 0; s < FracBits; s++) begin : g_fr
    for (genvar a = 0; a < 2; a++) begin : g_ax
      logic [DenW:0] tr;
      assign tr = {fr[a][s], 1'b0} - {1'b0, fd[s]};
      always_ff @(posedge clk) begin
        if (en) begin
          fr[a][s+1] <= tr[DenW] ? fr[a][s] << 1 : tr[DenW-1:0];
          fb[a][s+1] <= {fb[a][s][FracBits-2:0], ~tr[DenW]};
          fq[a][s+1] <= fq[a][s];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        fv[s+1] <= 1'b0;
      end else if (en) begin
        fv[s+1] <= fv[s];
      end
      if (en) begin
        fd[s+1]  <= fd[s];
        fbh[s+1] <= fbh[s];
      end
    end
  end

  // final stage: combine and saturate
  function automatic logic signed [CoordW-1:0] finish(
    input logic signed [63:0] q, input logic [FracBits-1:0] f);
    logic signed [63:0] v;
    v = (q <<< FracBits) + 64'($signed({1'b0, f}));
    if (q >= Lim) begin
      finish = sat32(64'sd2147483647);
    end else if (q < -Lim) begin
      finish = sat32(-64'sd2147483648);
    end else begin
      finish = sat32(v);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= fv[FracBits];
    end
    if (en) begin
      result.behind <= fbh[FracBits];
      result.x <= fbh[FracBits] ? NegOne : finish(fq[0][FracBits], fb[0][FracBits]);
      result.y <= fbh[FracBits] ? NegOne : finish(fq[1][FracBits], fb[1][FracBits]);
    end
  end

  logic unused;
  assign unused = dvy ^ ty[2] ^ tx[0] ^ ty[1] ^ (|dy_o);

endmodule

@@ rtl/perspective_world_to_screen_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_world_to_screen_unit
// projects world points to viewport pixels through a stored 4x4 matrix
// ----------------------------------------------------------------------------
// One word per cycle in and out while the output is not stalled. A point
// passes 3 clip stages, 3 scale stages, 50 quotient stages, 1 floor stage,
// FRAC_BITS fraction stages and one output stage; the dividers resolve one
// bit per stage. Coefficient words update the matrix and return nothing. The
// whole pipeline advances when the output register is empty or being taken.
module perspective_world_to_screen_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [14:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // coef_index, coef_value, world_x, world_y, world_z (lsb first)
  input  logic [135:0] s_tdata,
  // mode
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // screen_x, screen_y (lsb first)
  output logic [63:0]  m_tdata,
  // behind_camera
  output logic         m_tuser
);
  import pws_pkg::*;

  logic [DimW-1:0] screen_width, screen_height;
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= DimW'(1920);
      screen_height <= DimW'(1080);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_WIDTH:  screen_width  <= cfg_data;
        REG_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic                     cv;
  logic signed [CoordW-1:0] cx, cy, cw;
  pws_clip #(.FracBits(FRAC_BITS)) u_clip (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid),
    .mode(s_tuser), .coef_index(s_tdata[3:0]),
    .coef_value(s_tdata[35:4]), .world_x(s_tdata[67:36]),
    .world_y(s_tdata[99:68]), .world_z(s_tdata[131:100]),
    .out_valid(cv), .cx(cx), .cy(cy), .cw(cw)
  );

  screen_t res;
  pws_viewport #(.FracBits(FRAC_BITS)) u_view (
    .clk(clk), .rst(rst), .en(en), .in_valid(cv), .cx(cx), .cy(cy), .cw(cw),
    .screen_width(screen_width), .screen_height(screen_height),
    .out_valid(m_tvalid), .result(res)
  );

  assign m_tdata = {res.y, res.x};
  assign m_tuser = res.behind;

  logic unused;
  assign unused = ^s_tdata[135:132];

endmodule

@@ rtl/pws_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pws_checker
// port-level checks of the perspective world to screen unit
// ----------------------------------------------------------------------------
module pws_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser
);

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready)) else $error("ready mismatch");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled word changed");

  a_behind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[31:0] == m_tdata[63:32])
    else $error("behind word not symmetric");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("valid after reset");

endmodule

bind perspective_world_to_screen_unit pws_checker u_pws_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
